// File: hw/rtl/rldu_pkg.sv
// Shared constants and types for the record decrypt and unshuffle unit.
package rldu_pkg;

	typedef logic [1:0] block_t;
	typedef logic [4:0] slot_t;

	localparam logic [31:0] LCG_MUL      = 32'h41C6_4E6D;
	localparam logic [31:0] LCG_ADD      = 32'h0000_6073;
	localparam int          HEADER_WORDS = 4;
	localparam slot_t       ORDER_COUNT  = 5'd24;

	// Result block i of order slot s is taken from source block ORDER_TAB[i][s].
	localparam block_t ORDER_TAB [0:3][0:23] = '{
		'{2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd3, 2'd2, 2'd3,
		  2'd1, 2'd1, 2'd2, 2'd3, 2'd2, 2'd3, 2'd1, 2'd1, 2'd2, 2'd3, 2'd2, 2'd3},
		'{2'd1, 2'd1, 2'd2, 2'd3, 2'd2, 2'd3, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0,
		  2'd2, 2'd3, 2'd1, 2'd1, 2'd3, 2'd2, 2'd2, 2'd3, 2'd1, 2'd1, 2'd3, 2'd2},
		'{2'd2, 2'd3, 2'd1, 2'd1, 2'd3, 2'd2, 2'd2, 2'd3, 2'd1, 2'd1, 2'd3, 2'd2,
		  2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd3, 2'd2, 2'd3, 2'd2, 2'd1, 2'd1},
		'{2'd3, 2'd2, 2'd3, 2'd2, 2'd1, 2'd1, 2'd3, 2'd2, 2'd3, 2'd2, 2'd1, 2'd1,
		  2'd3, 2'd2, 2'd3, 2'd2, 2'd1, 2'd1, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0}
	};

endpackage

// File: hw/rtl/record_lcg_decrypt_unshuffle_unit.sv
// Record decrypt and block unshuffle unit: one encrypted word in, one placed word out.
//
// Usage:
// The input channel (in_valid, in_stall, data_word, last_word) takes the record's
// 16-bit words in order. Words 0 and 1 are the key; words 0 to 3 come out unchanged.
// Every later word is XORed with the upper half of the next generator state.
// The output channel (out_valid, out_stall, plain_word, dest_index, record_end)
// gives one word per input word, with the position it takes in the unshuffled
// record, so a receiver can scatter it straight into a buffer.
// A set last_word ends the record; the next word is word 0 of a new record.
// A taken word passes through the input register and then the result register,
// which drives the output; it moves on only while the output register is free.
// Throughput: one word per cycle when not stalled, set by the single 32-bit
// generator step (one multiply and add) between the input and result registers.
// A stalled result holds; the input register still takes one more word, and
// in_stall rises only while both registers are full and the output is stalled.
// Reset clears both valid flags, the word position, key, seed and order slot.
module record_lcg_decrypt_unshuffle_unit #(
	parameter int RECORD_WORDS = 116,
	parameter int BLOCK_WORDS  = 28
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] data_word,
	input  logic        last_word,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] plain_word,
	output logic [6:0]  dest_index,
	output logic        record_end
);

	localparam int CW  = $clog2(RECORD_WORDS);
	localparam int OW  = (BLOCK_WORDS > 1) ? $clog2(BLOCK_WORDS) : 1;
	localparam int DW  = $clog2(rldu_pkg::HEADER_WORDS + 4 * BLOCK_WORDS);
	localparam int XW0 = (CW > DW) ? CW : DW;
	localparam int XW  = (XW0 > 7) ? XW0 : 7;

	// Input register.
	logic        valid_s1;
	logic [15:0] data_s1;
	logic        last_s1;

	// Result register.
	logic        out_valid_q;
	logic [15:0] plain_q;
	logic [6:0]  dest_q;
	logic        end_q;

	// Record state.
	logic [CW-1:0]       count_q;
	logic [15:0]         key_low_q;
	logic [31:0]         seed_q;
	rldu_pkg::slot_t     slot_q;
	logic [2:0]          blk_q;
	logic [OW-1:0]       off_q;

	logic                advance;
	logic                accept;
	logic [CW-1:0]       count_n;
	logic [15:0]         key_low_n;
	logic [31:0]         seed_n;
	rldu_pkg::slot_t     slot_n;
	logic [2:0]          blk_n;
	logic [OW-1:0]       off_n;
	logic [31:0]         seed_step;
	rldu_pkg::slot_t     slot_raw;
	rldu_pkg::block_t    tgt;
	logic [DW-1:0]       dest_blk;
	logic [XW-1:0]       dest_n;
	logic [15:0]         plain_n;
	logic                wrap;

	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	assign seed_step = seed_q * rldu_pkg::LCG_MUL + rldu_pkg::LCG_ADD;
	assign slot_raw  = {data_s1[1:0], key_low_q[15:13]};

	always_comb begin
		plain_n   = data_s1;
		dest_n    = XW'(count_q);
		key_low_n = key_low_q;
		seed_n    = seed_q;
		slot_n    = slot_q;
		blk_n     = blk_q;
		off_n     = off_q;
		tgt       = blk_q[1:0];
		dest_blk  = '0;

		// First result block whose source is this word's block.
		for (int i = 3; i >= 0; i--) begin
			if (rldu_pkg::ORDER_TAB[i][slot_q] == blk_q[1:0]) begin
				tgt = 2'(i);
			end
		end

		if (count_q == '0) begin
			key_low_n = data_s1;
		end else if (count_q == CW'(1)) begin
			seed_n = {data_s1, key_low_q};
			slot_n = (slot_raw >= rldu_pkg::ORDER_COUNT) ?
				slot_raw - rldu_pkg::ORDER_COUNT : slot_raw;
		end else if (32'(count_q) >= rldu_pkg::HEADER_WORDS) begin
			seed_n  = seed_step;
			plain_n = data_s1 ^ seed_step[31:16];
			if (blk_q < 3'd4) begin
				dest_blk = DW'(rldu_pkg::HEADER_WORDS) + DW'(tgt) * DW'(BLOCK_WORDS)
					+ DW'(off_q);
				if ({{(32-DW){1'b0}}, dest_blk} < 32'(RECORD_WORDS)) begin
					dest_n = XW'(dest_blk);
				end
				if (off_q == OW'(BLOCK_WORDS - 1)) begin
					off_n = '0;
					blk_n = blk_q + 3'd1;
				end else begin
					off_n = off_q + OW'(1);
				end
			end
		end

		wrap = last_s1 || (32'(count_q) >= 32'(RECORD_WORDS - 1));
		if (wrap) begin
			count_n = '0;
			blk_n   = '0;
			off_n   = '0;
		end else begin
			count_n = count_q + CW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			data_s1 <= data_word;
			last_s1 <= last_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			count_q     <= '0;
			key_low_q   <= '0;
			seed_q      <= '0;
			slot_q      <= '0;
			blk_q       <= '0;
			off_q       <= '0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
			if (valid_s1) begin
				count_q   <= count_n;
				key_low_q <= key_low_n;
				seed_q    <= seed_n;
				slot_q    <= slot_n;
				blk_q     <= blk_n;
				off_q     <= off_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			plain_q <= plain_n;
			dest_q  <= dest_n[6:0];
			end_q   <= last_s1;
		end
	end

	assign out_valid  = out_valid_q;
	assign plain_word = plain_q;
	assign dest_index = dest_q;
	assign record_end = end_q;

	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		slot_q < rldu_pkg::ORDER_COUNT)
		else $error("order slot out of range");

	a_blk_range: assert property (@(posedge clk) disable iff (!arst_n)
		blk_q <= 3'd4)
		else $error("block counter out of range");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid_q))
		else $error("input stalled with a free register");

	a_last_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && valid_s1 && last_s1) |=> (count_q == '0 && blk_q == '0))
		else $error("record did not restart after last word");

	a_dest_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && RECORD_WORDS <= 128) |-> (32'(dest_q) < 32'(RECORD_WORDS)))
		else $error("destination beyond record");

endmodule
